FILE: src/mbd_pkg.sv
// Shared types and constants of the mipmap box downsampler.
package mbd_pkg;

  localparam int unsigned DefaultMaxWidth = 4096;
  localparam int unsigned DimW            = 13;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned PairW           = ChanW + 1;

  typedef logic [DimW-1:0] dim_t;
  typedef logic [0:0]      cfg_idx_t;

  localparam cfg_idx_t CfgSourceWidth  = 1'b0;
  localparam cfg_idx_t CfgSourceHeight = 1'b1;

  localparam dim_t ResetDim = 13'd256;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  // Horizontal pair sums, one extra bit per channel.
  typedef struct packed {
    logic [PairW-1:0] alpha;
    logic [PairW-1:0] blue;
    logic [PairW-1:0] green;
    logic [PairW-1:0] red;
  } pair_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_cmd_t;

endpackage

FILE: src/mbd_ifs.sv
// Valid/ready stream interfaces for source pixels and averaged pixels.
interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface mbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       last_pixel;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output last_pixel, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, input last_pixel, output ready);
endinterface

FILE: src/mbd_pair_store.sv
// Half-row store of even-row pair sums, one write or one registered read per cycle.
module mbd_pair_store import mbd_pkg::*; #(
  parameter int unsigned DEPTH  = DefaultMaxWidth / 2,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk,
  input  store_cmd_t        cmd,
  input  logic [ADDR_W-1:0] addr,
  input  pair_t             wdata,
  output pair_t             rdata
);

  pair_t mem [DEPTH];
  pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mipmap_box_downsample.sv
// Top level of the streaming 2x2 box-filter mipmap downsampler.
// Path: the odd-row, odd-column source beat loads stage one, which feeds the output register.
// Throughput: one source pixel per clock, set by the single-port half-row store, unless the output backs up.
// Reset (synchronous, rst_n low): counters, held pixel and valid flags clear, and both
// dimension registers return to 256. The half-row store is not cleared; every entry
// is written by an even row before the following odd row reads it.
module mipmap_box_downsample import mbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefaultMaxWidth
) (
  input  logic     clk,
  input  logic     rst_n,
  mbd_in_if.sink   in_ch,
  mbd_out_if.source out_ch,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_idx,
  input  dim_t     cfg_data
);

  // The store holds one pair sum per output column.
  localparam int unsigned StoreDepth = MAX_WIDTH / 2;
  localparam int unsigned StoreAddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  // Width cap in source columns; it only matters when MAX_WIDTH fits the width register.
  localparam int unsigned CapWidth   = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam dim_t        WidthCapHalf = DimW'(CapWidth / 2);

  // Configuration registers.
  dim_t src_w_r;
  dim_t src_h_r;

  // Position of the next source pixel and the even-column pixel waiting for its partner.
  dim_t   col_r, col_nxt;
  dim_t   row_r, row_nxt;
  pixel_t left_r;

  // Stage one: pair sum of the odd row, waiting for the registered store read.
  logic  s1_valid_r;
  pair_t s1_pair_r;
  logic  s1_last_r;

  // Output register.
  logic   out_valid_r;
  pixel_t out_pix_r;
  logic   out_last_r;

  pixel_t      in_pix;
  logic        accept;
  logic        s1_adv;
  dim_t        out_w, out_h;
  logic [11:0] col_half, row_half;
  logic        in_range;
  logic        last_now;
  pair_t       pair_now;
  pair_t       above;
  store_cmd_t  store_cmd;
  logic        col_end, row_end;

  function automatic pair_t pair_add(pixel_t a, pixel_t b);
    pair_t s;
    s.red   = {1'b0, a.red}   + {1'b0, b.red};
    s.green = {1'b0, a.green} + {1'b0, b.green};
    s.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
    s.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
    return s;
  endfunction

  // Sum of four pixels divided by four with truncation.
  function automatic pixel_t block_avg(pair_t a, pair_t b);
    logic [PairW:0] r, g, bl, al;
    pixel_t         p;
    r  = {1'b0, a.red}   + {1'b0, b.red};
    g  = {1'b0, a.green} + {1'b0, b.green};
    bl = {1'b0, a.blue}  + {1'b0, b.blue};
    al = {1'b0, a.alpha} + {1'b0, b.alpha};
    p.red   = r[PairW:2];
    p.green = g[PairW:2];
    p.blue  = bl[PairW:2];
    p.alpha = al[PairW:2];
    return p;
  endfunction

  assign in_pix = '{alpha: in_ch.alpha_in, blue: in_ch.blue_in,
                    green: in_ch.green_in, red: in_ch.red_in};

  // Stage one moves on when the output register is empty or being drained. A new
  // source beat is taken whenever stage one is empty or moves on in this cycle.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Output dimensions; columns past the store capacity produce nothing.
  assign out_w = (32'(src_w_r) < MAX_WIDTH) ? {1'b0, src_w_r[DimW-1:1]} : WidthCapHalf;
  assign out_h = {1'b0, src_h_r[DimW-1:1]};

  assign col_half = col_r[DimW-1:1];
  assign row_half = row_r[DimW-1:1];

  // An odd column closes a horizontal pair; it counts only inside the output image.
  assign in_range = col_r[0] && ({1'b0, col_half} < out_w) && ({1'b0, row_half} < out_h);
  assign last_now = ({1'b0, col_half} == out_w - 1'b1) &&
                    ({1'b0, row_half} == out_h - 1'b1);
  assign pair_now = pair_add(left_r, in_pix);

  // Even rows deposit their pair sums, odd rows fetch the pair from the row above.
  assign store_cmd.wr = accept && in_range && !row_r[0];
  assign store_cmd.rd = accept && in_range && row_r[0];

  mbd_pair_store #(
    .DEPTH  (StoreDepth),
    .ADDR_W (StoreAddrW)
  ) u_store (
    .clk   (clk),
    .cmd   (store_cmd),
    .addr  (StoreAddrW'(col_half)),
    .wdata (pair_now),
    .rdata (above)
  );

  // Raster counters. A zero dimension behaves like one since the compare always hits.
  assign col_end = ({1'b0, col_r} + 14'd1) >= {1'b0, src_w_r};
  assign row_end = ({1'b0, row_r} + 14'd1) >= {1'b0, src_h_r};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= ResetDim;
      src_h_r     <= ResetDim;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CfgSourceWidth:  src_w_r <= cfg_data;
          CfgSourceHeight: src_h_r <= cfg_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept && !col_r[0]) begin
        left_r <= in_pix;
      end
      if (store_cmd.rd) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers follow their valid flags and need no reset.
  always_ff @(posedge clk) begin
    if (store_cmd.rd) begin
      s1_pair_r <= pair_now;
      s1_last_r <= last_now;
    end
    if (s1_adv) begin
      out_pix_r  <= block_avg(above, s1_pair_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = out_pix_r.red;
  assign out_ch.green_out  = out_pix_r.green;
  assign out_ch.blue_out   = out_pix_r.blue;
  assign out_ch.alpha_out  = out_pix_r.alpha;
  assign out_ch.last_pixel = out_last_r;

  // Every odd-row block that is read from the store reaches stage one.
  a_read_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    store_cmd.rd |=> s1_valid_r)
    else $error("store read did not load stage one");

  // A stalled stage one keeps its beat; the store read data must not be lost.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && !$past(store_cmd.rd)))
    else $error("stage one dropped or overwrote a stalled beat");

  // Stage one only moves into a free or draining output register.
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !s1_adv)
    else $error("output register overrun");

endmodule

FILE: sim/tb_mipmap_box_downsample.sv
// Self-checking testbench for the 2x2 box-filter mipmap downsampler.
module tb_mipmap_box_downsample;
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  localparam int unsigned MaxWidth      = DefaultMaxWidth;
  localparam int unsigned StoreDepth    = MaxWidth / 2;
  localparam int          CycleLimit    = 1_000_000;
  // The block answers through stage one and its output register; this margin covers
  // beats that make no output but are still in flight.
  localparam int          SettleCycles  = 4;
  localparam int          TailCycles    = 10;
  localparam int          RandomBeats   = 1840;
  // Width of the image that primes the half-row store after the directed rows.
  localparam int unsigned FillWidth     = 16;
  // Source beats of the directed table.
  localparam int          DirectedBeats = 26;
  // The long output stall starts halfway through the odd row of the priming image.
  localparam int          SqueezeBeat   = DirectedBeats + FillWidth + FillWidth / 2;
  localparam int          SqueezeCycles = 600;

  // One averaged output pixel as the result channel carries it.
  typedef struct packed {
    logic   last;
    pixel_t px;
  } block_avg_t;

  typedef enum logic {StepWrite, StepPixel} step_kind_t;
  typedef enum logic [1:0] {RxOpen, RxMostly, RxSparse, RxToggle} rx_mode_t;

  // One row of the directed table: a register write or a source pixel, with the
  // averaged pixel typed in where it is obvious.
  typedef struct {
    step_kind_t kind;
    cfg_idx_t   idx;
    dim_t       value;
    pixel_t     px;
    bit         listed;
    block_avg_t avg;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_idx;
  dim_t       cfg_data;
  // Typed-in expectation that travels with the source beat currently offered.
  logic       listed_on;
  block_avg_t listed_avg;

  mbd_in_if  in_ch ();
  mbd_out_if out_ch ();

  mipmap_box_downsample #(.MAX_WIDTH(MaxWidth)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: dimension registers, the half-row store of pair sums,
  // the pixel held from the even column and the raster position.
  dim_t   src_w;
  dim_t   src_h;
  pair_t  pair_rows [StoreDepth];
  pixel_t left_px;
  dim_t   col_pos;
  dim_t   row_pos;

  block_avg_t  avg_due [$];
  script_row_t script_rows [$];

  int errors     = 0;
  int in_beats   = 0;
  int out_beats  = 0;
  int reg_writes = 0;
  int dim_sets   = 0;
  int burst_left = 0;

  // Raster position after one source pixel. A counter at or past the end of
  // its row or image wraps, which also covers zero dimensions.
  function automatic void step_position(input dim_t w, input dim_t h,
                                        inout dim_t col, inout dim_t row);
    int unsigned c;
    int unsigned r;
    c = col;
    r = row;
    if (c + 1 >= w) begin
      col = '0;
      if (r + 1 >= h) begin
        row = '0;
      end else begin
        row = DimW'(r + 1);
      end
    end else begin
      col = DimW'(c + 1);
    end
  endfunction

  // Sum of two pair sums divided by four, truncated.
  function automatic logic [ChanW-1:0] quarter_of(input logic [PairW-1:0] a,
                                                  input logic [PairW-1:0] b);
    logic [PairW:0] s;
    s = a + b;
    return s[PairW:2];
  endfunction

  // Takes one accepted source pixel and reports the averaged pixel it completes,
  // if any. Even rows park their pair sums; odd rows combine with them.
  task automatic filter_pixel(input pixel_t px, output bit produced,
                              output block_avg_t avg);
    int unsigned eff_w;
    int unsigned out_w;
    int unsigned out_h;
    int unsigned half_x;
    int unsigned half_y;
    pair_t       pair;
    pair_t       above;
    produced = 1'b0;
    avg      = '0;
    eff_w  = (src_w < MaxWidth) ? src_w : MaxWidth;
    out_w  = eff_w / 2;
    out_h  = src_h / 2;
    half_x = col_pos >> 1;
    half_y = row_pos >> 1;
    if (!col_pos[0]) begin
      left_px = px;
    end else if (half_x < out_w && half_y < out_h) begin
      pair.red   = left_px.red + px.red;
      pair.green = left_px.green + px.green;
      pair.blue  = left_px.blue + px.blue;
      pair.alpha = left_px.alpha + px.alpha;
      if (!row_pos[0]) begin
        pair_rows[half_x] = pair;
      end else begin
        above        = pair_rows[half_x];
        avg.px.red   = quarter_of(above.red, pair.red);
        avg.px.green = quarter_of(above.green, pair.green);
        avg.px.blue  = quarter_of(above.blue, pair.blue);
        avg.px.alpha = quarter_of(above.alpha, pair.alpha);
        avg.last     = (half_x == out_w - 1) && (half_y == out_h - 1);
        produced     = 1'b1;
      end
    end
    step_position(src_w, src_h, col_pos, row_pos);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Everything is sampled at the rising edge: register writes and accepted
  // source beats update the shadow, accepted output beats are compared.
  always @(posedge clk) begin : monitor
    bit         produced;
    block_avg_t avg;
    block_avg_t due;
    block_avg_t want;
    if (!rst_n) begin
      src_w   = ResetDim;
      src_h   = ResetDim;
      left_px = '0;
      col_pos = '0;
      row_pos = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CfgSourceWidth) begin
          src_w = cfg_data;
        end else begin
          src_h = cfg_data;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_beats++;
        filter_pixel({in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in},
                     produced, avg);
        if (produced) begin
          due     = listed_on ? listed_avg : avg;
          avg_due = {avg_due, due};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (avg_due.size() == 0) begin
          $error("output beat with no averaged pixel pending");
          errors++;
        end else begin
          want = avg_due.pop_front();
          check_field("red_out", want.px.red, out_ch.red_out);
          check_field("green_out", want.px.green, out_ch.green_out);
          check_field("blue_out", want.px.blue, out_ch.blue_out);
          check_field("alpha_out", want.px.alpha, out_ch.alpha_out);
          check_field("last_pixel", want.last, out_ch.last_pixel);
        end
      end
    end
  end

  // The receiver switches between open, mostly ready, sparse and toggling
  // stretches. Once, inside an odd row, it refuses output for a long
  // stretch so that the block backs up and holds off source beats.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    bit       squeezed;
    out_ch.ready = 1'b0;
    mode_left    = 0;
    squeezed     = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && in_beats >= SqueezeBeat) begin
        squeezed = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SqueezeCycles - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RxOpen:   out_ch.ready <= 1'b1;
          RxMostly: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RxSparse: out_ch.ready <= ($urandom_range(0, 9) < 3);
          default:  out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  // The sender works in bursts. Between bursts valid drops for a random gap,
  // and now and then a burst runs for hundreds of beats without a break.
  task automatic offer_pixel(input pixel_t px, input bit listed, input block_avg_t avg);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= px.red;
    in_ch.green_in <= px.green;
    in_ch.blue_in  <= px.blue;
    in_ch.alpha_in <= px.alpha;
    listed_on      <= listed;
    listed_avg     <= avg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drains the block: no source beat offered, every averaged pixel delivered,
  // and a margin of SettleCycles for beats that make no output.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (avg_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input dim_t value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_dims(input dim_t w, input dim_t h);
    settle();
    write_reg(CfgSourceWidth, w);
    write_reg(CfgSourceHeight, h);
    dim_sets++;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    case ($urandom_range(0, 7))
      0:       p = '1;
      1:       p = '0;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic stream_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      offer_pixel(random_pixel(), 1'b0, '0);
    end
  endtask

  // Source beats still needed until the raster position is back at the origin.
  function automatic int unsigned beats_to_wrap(input dim_t w, input dim_t h,
                                                input dim_t col, input dim_t row);
    int unsigned n;
    n = 0;
    while (col != '0 || row != '0) begin
      step_position(w, h, col, row);
      n++;
    end
    return n;
  endfunction

  function automatic dim_t odd_dim();
    case ($urandom_range(0, 5))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return DimW'(MaxWidth);
      3:       return '1;
      default: return DimW'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic pixel_t rgba(input int r, input int g, input int b, input int a);
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  task automatic add_write(input cfg_idx_t idx, input dim_t value);
    script_row_t row;
    row         = '{kind: StepWrite, default: '0};
    row.idx     = idx;
    row.value   = value;
    script_rows = {script_rows, row};
  endtask

  task automatic add_pixel(input pixel_t px, input bit listed, input block_avg_t avg);
    script_row_t row;
    row         = '{kind: StepPixel, default: '0};
    row.px      = px;
    row.listed  = listed;
    row.avg     = avg;
    script_rows = {script_rows, row};
  endtask

  // The run stops here if it hangs: a plain count of clock cycles.
  initial begin : watchdog
    for (int n = 0; n < CycleLimit; n++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    dim_t        w;
    dim_t        h;
    int unsigned n;
    int unsigned small_beats;
    int          kind;
    bit          dims_fresh;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    in_ch.alpha_in = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgSourceWidth;
    cfg_data       = '0;
    listed_on      = 1'b0;
    listed_avg     = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // A 4x2 image: one block of all ones and one of all zeros, the second one
    // closing the level.
    add_write(CfgSourceWidth, 13'd4);
    add_write(CfgSourceHeight, 13'd2);
    add_pixel(rgba(255, 255, 255, 255), 1'b0, '0);
    add_pixel(rgba(255, 255, 255, 255), 1'b0, '0);
    add_pixel(rgba(0, 0, 0, 0), 1'b0, '0);
    add_pixel(rgba(0, 0, 0, 0), 1'b0, '0);
    add_pixel(rgba(255, 255, 255, 255), 1'b0, '0);
    add_pixel(rgba(255, 255, 255, 255), 1'b1, {1'b0, rgba(255, 255, 255, 255)});
    add_pixel(rgba(0, 0, 0, 0), 1'b0, '0);
    add_pixel(rgba(0, 0, 0, 0), 1'b1, {1'b1, rgba(0, 0, 0, 0)});
    // A 3x3 image: the trailing column and row are consumed without output,
    // and the single block exercises truncation of the average.
    add_write(CfgSourceWidth, 13'd3);
    add_write(CfgSourceHeight, 13'd3);
    add_pixel(rgba(255, 0, 1, 128), 1'b0, '0);
    add_pixel(rgba(254, 255, 2, 127), 1'b0, '0);
    add_pixel(rgba(90, 165, 60, 195), 1'b0, '0);
    add_pixel(rgba(255, 0, 3, 128), 1'b0, '0);
    add_pixel(rgba(255, 1, 4, 129), 1'b0, '0);
    add_pixel(rgba(17, 34, 51, 68), 1'b0, '0);
    add_pixel(rgba(7, 200, 13, 250), 1'b0, '0);
    add_pixel(rgba(128, 64, 32, 16), 1'b0, '0);
    add_pixel(rgba(1, 2, 4, 8), 1'b0, '0);
    // A one-pixel-wide image and a zero-size image give no output at all.
    add_write(CfgSourceWidth, 13'd1);
    add_write(CfgSourceHeight, 13'd2);
    add_pixel(rgba(255, 255, 255, 255), 1'b0, '0);
    add_pixel(rgba(170, 85, 170, 85), 1'b0, '0);
    add_write(CfgSourceWidth, 13'd0);
    add_write(CfgSourceHeight, 13'd0);
    add_pixel(rgba(85, 170, 85, 170), 1'b0, '0);
    // A 2x4 image cut short: after the first block the height drops to 2 while
    // the row counter already sits at 2, so the next row ends the image.
    add_write(CfgSourceWidth, 13'd2);
    add_write(CfgSourceHeight, 13'd4);
    add_pixel(rgba(10, 20, 30, 40), 1'b0, '0);
    add_pixel(rgba(50, 60, 70, 80), 1'b0, '0);
    add_pixel(rgba(90, 100, 110, 120), 1'b0, '0);
    add_pixel(rgba(130, 140, 150, 160), 1'b0, '0);
    add_write(CfgSourceHeight, 13'd2);
    add_pixel(rgba(3, 6, 9, 12), 1'b0, '0);
    add_pixel(rgba(15, 18, 21, 24), 1'b0, '0);

    foreach (script_rows[i]) begin
      if (script_rows[i].kind == StepWrite) begin
        settle();
        write_reg(script_rows[i].idx, script_rows[i].value);
      end else begin
        offer_pixel(script_rows[i].px, script_rows[i].listed, script_rows[i].avg);
      end
    end
    dim_sets += 5;

    // A 16-wide image writes the first eight entries of the half-row store,
    // which are all that a mid-image size change further on can reach, so no
    // entry is read before it was written. The long output stall lands in its
    // odd row.
    set_dims(DimW'(FillWidth), 13'd2);
    stream_pixels(FillWidth * 2);

    small_beats = 0;
    dims_fresh  = 1'b0;
    w           = '0;
    h           = '0;
    while (small_beats < RandomBeats) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Well-formed images, and now and then the same size again so that
        // one image follows the other with no register write in between.
        if (kind != 0 || !dims_fresh) begin
          w = DimW'($urandom_range(2, 24));
          h = DimW'($urandom_range(2, 10));
          set_dims(w, h);
        end
        n = w * h;
        stream_pixels(n);
        small_beats += n;
        dims_fresh = 1'b1;
      end else if (kind == 7) begin
        // Degenerate sizes: a width or height of zero or one gives no output.
        if ($urandom_range(0, 1) == 0) begin
          w = DimW'($urandom_range(0, 1));
          h = DimW'($urandom_range(0, 12));
        end else begin
          w = DimW'($urandom_range(0, 24));
          h = DimW'($urandom_range(0, 1));
        end
        set_dims(w, h);
        n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
        stream_pixels(n);
        small_beats += n;
        dims_fresh = 1'b1;
      end else begin
        // Broken image: arbitrary register values, a few beats, then a small
        // size written mid-image and enough beats to wrap back to the origin.
        set_dims(odd_dim(), odd_dim());
        n = $urandom_range(1, 40);
        stream_pixels(n);
        small_beats += n;
        w = DimW'($urandom_range(2, 16));
        h = DimW'($urandom_range(2, 8));
        set_dims(w, h);
        n = beats_to_wrap(w, h, col_pos, row_pos);
        stream_pixels(n);
        small_beats += n;
        dims_fresh = 1'b1;
      end
    end

    settle();
    repeat (TailCycles) @(negedge clk);

    $display("Run covered %0d source beats under %0d image sizes and %0d register writes,",
             in_beats, dim_sets, reg_writes);
    $display("with %0d averaged beats checked and one %0d-cycle output stall.",
             out_beats, SqueezeCycles);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mbd_pkg.sv
src/mbd_ifs.sv
src/mbd_pair_store.sv
src/mipmap_box_downsample.sv
sim/tb_mipmap_box_downsample.sv
